>>> hw/rtl/gfa_pkg.sv
// ============================================================================
// gfa_pkg: shared types and constants of the GF(2^8) arithmetic unit
// Beat formats of the command and result channels, operation codes and the
// field helper used by the sequencer.
// ============================================================================
`default_nettype none

package gfa_pkg;

    localparam int unsigned GfWidth = 8;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_INV = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [GfWidth-1:0] operand_a;
        logic [GfWidth-1:0] operand_b;
    } t_gfa_in;

    typedef struct packed {
        logic [GfWidth-1:0] result;
        logic               not_invertible;
    } t_gfa_out;

    typedef struct packed {
        logic busy;
        logic valid;
    } t_gfa_stat;

    // Degree of a nine-bit polynomial; the zero polynomial also gives 0.
    function automatic logic [3:0] gfa_degree(input logic [GfWidth:0] p);
        logic [3:0] d;
        d = 4'd0;
        for (int i = 0; i <= GfWidth; i++) begin
            if (p[i]) begin
                d = 4'(i);
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gfa_xpow.sv
// ============================================================================
// gfa_xpow: multiply a field element by x^s modulo the reduction polynomial
// Shared arithmetic unit; the shift amount runs from zero to eight and each
// step is one multiplication by x with a conditional reduction.
// ============================================================================
`default_nettype none

module gfa_xpow
    import gfa_pkg::*;
(
    input  wire logic [GfWidth-1:0] i_poly_low,
    input  wire logic [GfWidth-1:0] i_value,
    input  wire logic [3:0]         i_shift,
    output logic      [GfWidth-1:0] o_value
);

    always_comb begin
        logic [GfWidth-1:0] v;
        v = i_value;
        for (int i = 0; i < GfWidth; i++) begin
            if (4'(i) < i_shift) begin
                v = {v[GfWidth-2:0], 1'b0} ^ (v[GfWidth-1] ? i_poly_low : '0);
            end
        end
        o_value = v;
    end

endmodule

`default_nettype wire

>>> hw/rtl/gfa_seq.sv
// ============================================================================
// gfa_seq: operation sequencer of the GF(2^8) arithmetic unit
// Runs multiply as eight shift-and-add steps and inverse as an extended
// Euclidean reduction that removes one quotient term per cycle, both through
// the shared multiply-by-x^s unit, and registers the result beat.
// ============================================================================
`default_nettype none

module gfa_seq
    import gfa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [GfWidth-1:0] i_poly_low,
    input  wire logic               i_start,
    input  wire t_gfa_in            i_cmd,
    output t_gfa_stat               o_stat,
    output t_gfa_out                o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_INV  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [2:0]         r_cnt, n_cnt;
    logic [GfWidth-1:0] r_a, n_a;
    logic [GfWidth-1:0] r_b, n_b;
    logic [GfWidth:0]   r_r0, n_r0;
    logic [GfWidth:0]   r_r1, n_r1;
    logic [GfWidth-1:0] r_t0, n_t0;
    logic [GfWidth-1:0] r_t1, n_t1;
    logic               r_valid, n_valid;
    t_gfa_out           r_res, n_res;

    logic               swap;
    logic [GfWidth:0]   x, y;
    logic [GfWidth-1:0] tx, ty;
    logic [3:0]         shift;
    logic [GfWidth-1:0] xp_in, xp_out;
    logic [3:0]         xp_shift;
    logic [GfWidth-1:0] mul_next;

    assign swap  = gfa_degree(r_r0) < gfa_degree(r_r1);
    assign x     = swap ? r_r1 : r_r0;
    assign y     = swap ? r_r0 : r_r1;
    assign tx    = swap ? r_t1 : r_t0;
    assign ty    = swap ? r_t0 : r_t1;
    assign shift = gfa_degree(x) - gfa_degree(y);

    assign xp_in    = (r_state == ST_MUL) ? r_t0 : ty;
    assign xp_shift = (r_state == ST_MUL) ? 4'd1 : shift;

    gfa_xpow u_xpow (
        .i_poly_low (i_poly_low),
        .i_value    (xp_in),
        .i_shift    (xp_shift),
        .o_value    (xp_out)
    );

    assign mul_next = xp_out ^ (r_b[r_cnt] ? r_a : '0);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_b     = r_b;
        n_r0    = r_r0;
        n_r1    = r_r1;
        n_t0    = r_t0;
        n_t1    = r_t1;
        n_valid = 1'b0;
        n_res   = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd.opcode)
                        OP_ADD: begin
                            n_res.result         = i_cmd.operand_a ^ i_cmd.operand_b;
                            n_res.not_invertible = 1'b0;
                            n_valid              = 1'b1;
                        end
                        OP_MUL: begin
                            n_a     = i_cmd.operand_a;
                            n_b     = i_cmd.operand_b;
                            n_t0    = '0;
                            n_cnt   = 3'(GfWidth - 1);
                            n_state = ST_MUL;
                        end
                        OP_INV: begin
                            if (i_cmd.operand_a == '0) begin
                                n_res.result         = '0;
                                n_res.not_invertible = 1'b0;
                                n_valid              = 1'b1;
                            end else begin
                                n_r0    = {1'b1, i_poly_low};
                                n_r1    = {1'b0, i_cmd.operand_a};
                                n_t0    = '0;
                                n_t1    = GfWidth'(1);
                                n_state = ST_INV;
                            end
                        end
                        default: begin
                            n_res.result         = '0;
                            n_res.not_invertible = 1'b0;
                            n_valid              = 1'b1;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_t0 = mul_next;
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_res.result         = mul_next;
                    n_res.not_invertible = 1'b0;
                    n_valid              = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            ST_INV: begin
                if (r_r0 == '0) begin
                    if (r_r1 == (GfWidth+1)'(1)) begin
                        n_res.result         = r_t1;
                        n_res.not_invertible = 1'b0;
                    end else begin
                        n_res.result         = '0;
                        n_res.not_invertible = 1'b1;
                    end
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_r0 = x ^ (y << shift);
                    n_r1 = y;
                    n_t0 = tx ^ xp_out;
                    n_t1 = ty;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_r0  <= n_r0;
        r_r1  <= n_r1;
        r_t0  <= n_t0;
        r_t1  <= n_t1;
        r_res <= n_res;
    end

    assign o_stat.busy  = (r_state != ST_IDLE);
    assign o_stat.valid = r_valid;
    assign o_res        = r_res;

    a_valid_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == ST_IDLE))
        else $error("Result beat issued while an operation is still running.");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INV) |-> (r_r1 != '0))
        else $error("Euclidean divisor became zero.");

    a_mul_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start && i_cmd.opcode == OP_MUL)
            |=> (r_state == ST_MUL && r_cnt == 3'(GfWidth - 1)))
        else $error("Multiply did not start at the top operand bit.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.not_invertible) |-> (r_res.result == '0))
        else $error("Failed inverse returned a nonzero element.");

endmodule

`default_nettype wire

>>> hw/rtl/gf256_arith_unit.sv
// ============================================================================
// gf256_arith_unit: add, multiply and inverse over GF(2^8)
// Top level with the reduction polynomial register and the command port.
// ============================================================================
// A command beat is taken when start is high and busy is low. Add and the
// unused opcode, and inverse of zero, give their result beat on the next
// cycle and leave busy low. Multiply keeps busy high while it takes one
// operand bit per cycle, and inverse while it removes one quotient term of
// the Euclidean reduction per cycle; both pass through one shared
// multiply-by-x^s unit; the result beat comes the cycle after the last step.
// Each result beat is shown on o_res_data for exactly one cycle with
// o_res_valid high and cannot be held off. The polynomial register may be
// written only while busy is low and no result beat is pending.
`default_nettype none

module gf256_arith_unit
    import gfa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [GfWidth-1:0] i_cfg_wdata,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_gfa_in            i_op_data,
    output logic                    o_res_valid,
    output t_gfa_out                o_res_data
);

    localparam logic [GfWidth-1:0] PolyReset = GfWidth'(8'h1B);

    logic [GfWidth-1:0] r_poly_low;
    t_gfa_stat          stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_low <= PolyReset;
        end else if (i_cfg_we) begin
            r_poly_low <= i_cfg_wdata;
        end
    end

    gfa_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_poly_low (r_poly_low),
        .i_start    (start),
        .i_cmd      (i_op_data),
        .o_stat     (stat),
        .o_res      (o_res_data)
    );

    assign busy        = stat.busy;
    assign o_res_valid = stat.valid;

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking testbench of the GF(2^8) arithmetic unit
// Drives command beats of add, multiply, inverse and the unused opcode under
// several reduction polynomials, irreducible and reducible ones among them.
// A small scoreboard predicts every result beat from the polynomial in force
// and compares it field by field with what the unit returns.
// ============================================================================

module tb_top;
    import gfa_pkg::*;

    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned DrainCycles = 24;
    localparam int unsigned BlockItems  = 108;
    localparam logic [1:0]  OP_NONE     = 2'd3;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [GfWidth-1:0] i_cfg_wdata = '0;
    logic               start       = 1'b0;
    logic               busy;
    t_gfa_in            i_op_data   = '0;
    logic               o_res_valid;
    t_gfa_out           o_res_data;

    int unsigned cycles = 0;

    class gf_result_board;
        logic [7:0]  poly_low;
        t_gfa_out    pending_results[$];
        t_gfa_in     pending_cmds[$];
        int unsigned mismatches;

        function new();
            poly_low   = 8'h1B;
            mismatches = 0;
        endfunction

        function int poly_deg(logic [31:0] p);
            int d;
            d = -1;
            for (int i = 0; i < 32; i++) begin
                if (p[i]) begin
                    d = i;
                end
            end
            return d;
        endfunction

        function logic [31:0] carryless_mul(logic [31:0] a, logic [31:0] b);
            logic [31:0] m;
            m = '0;
            for (int i = 0; i < 16; i++) begin
                if (b[i]) begin
                    m ^= (a & 32'hFFFF) << i;
                end
            end
            return m;
        endfunction

        function logic [7:0] reduce_product(logic [31:0] m);
            logic [31:0] p;
            p = {23'd0, 1'b1, poly_low};
            for (int d = 15; d >= 8; d--) begin
                if (m[d]) begin
                    m ^= p << (d - 8);
                end
            end
            return m[7:0];
        endfunction

        function t_gfa_out field_inverse(logic [7:0] a);
            logic [31:0] r0, r1, t0, t1, q, n, tn;
            int          dd, dn;
            t_gfa_out    res;
            r0 = {23'd0, 1'b1, poly_low};
            r1 = {24'd0, a};
            t0 = '0;
            t1 = 32'd1;
            for (int k = 0; k < 16 && r1 != 0; k++) begin
                n  = r0;
                q  = '0;
                dd = poly_deg(r1);
                dn = poly_deg(n);
                while (dn >= dd && dn >= 0) begin
                    q  |= 32'd1 << (dn - dd);
                    n  ^= r1 << (dn - dd);
                    dn = poly_deg(n);
                end
                tn = t0 ^ carryless_mul(q, t1);
                r0 = r1;
                r1 = n;
                t0 = t1 & 32'hFFFF;
                t1 = tn & 32'hFFFF;
            end
            if (r0 != 32'd1) begin
                res.result         = '0;
                res.not_invertible = 1'b1;
            end else begin
                res.result         = t0[7:0];
                res.not_invertible = 1'b0;
            end
            return res;
        endfunction

        function t_gfa_out field_result(t_gfa_in cmd);
            t_gfa_out res;
            res = '0;
            case (cmd.opcode)
                OP_ADD: begin
                    res.result = cmd.operand_a ^ cmd.operand_b;
                end
                OP_MUL: begin
                    res.result = reduce_product(carryless_mul({24'd0, cmd.operand_a},
                                                              {24'd0, cmd.operand_b}));
                end
                OP_INV: begin
                    if (cmd.operand_a != 0) begin
                        res = field_inverse(cmd.operand_a);
                    end
                end
                default: begin
                    res = '0;
                end
            endcase
            return res;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40) begin
                $display("ERROR at cycle %0d: %s", cycles, msg);
            end
        endtask

        function void note_command(t_gfa_in cmd);
            pending_cmds.push_back(cmd);
            pending_results.push_back(field_result(cmd));
        endfunction

        task check_result(t_gfa_out got);
            t_gfa_out want;
            t_gfa_in  cmd;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat %02h/%0d with no command outstanding",
                                          got.result, got.not_invertible));
            end else begin
                want = pending_results.pop_front();
                cmd  = pending_cmds.pop_front();
                if (got.result !== want.result) begin
                    report_mismatch($sformatf(
                        "op %0d a %02h b %02h poly %02h: result %02h, expected %02h",
                        cmd.opcode, cmd.operand_a, cmd.operand_b, poly_low,
                        got.result, want.result));
                end
                if (got.not_invertible !== want.not_invertible) begin
                    report_mismatch($sformatf(
                        "op %0d a %02h poly %02h: not_invertible %0d, expected %0d",
                        cmd.opcode, cmd.operand_a, poly_low,
                        got.not_invertible, want.not_invertible));
                end
            end
        endtask
    endclass

    gf_result_board board = new();

    gf256_arith_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_op_data   (i_op_data),
        .o_res_valid (o_res_valid),
        .o_res_data  (o_res_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note_command(i_op_data);
            end
            if (o_res_valid) begin
                board.check_result(o_res_data);
            end
        end
    end

    task automatic send_cmd(input logic [1:0] op, input logic [7:0] a, input logic [7:0] b);
        t_gfa_in cmd;
        cmd.opcode    = op;
        cmd.operand_a = a;
        cmd.operand_b = b;
        @(negedge i_clk);
        start     <= 1'b1;
        i_op_data <= cmd;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task automatic hold_off(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start     <= 1'b0;
            i_op_data <= t_gfa_in'($urandom);
        end
    endtask

    task automatic drain_results();
        hold_off(1);
        while (board.pending_results.size() != 0) begin
            hold_off(1);
        end
        hold_off(DrainCycles);
    endtask

    task automatic write_poly(input logic [7:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we       <= 1'b1;
        i_cfg_wdata    <= value;
        board.poly_low = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 8'($urandom);
    endtask

    function automatic logic [7:0] random_operand();
        logic [7:0] edges [4] = '{8'h00, 8'hFF, 8'h01, 8'h80};
        if ($urandom_range(7) == 0) begin
            return edges[$urandom_range(3)];
        end
        return 8'($urandom);
    endfunction

    task automatic random_block(input int unsigned n_items, input int unsigned idle_pct);
        int unsigned pick;
        logic [1:0]  op;
        for (int unsigned i = 0; i < n_items; i++) begin
            while ($urandom_range(99) < idle_pct) begin
                hold_off(1);
            end
            pick = $urandom_range(99);
            if (pick < 25) begin
                op = OP_ADD;
            end else if (pick < 55) begin
                op = OP_MUL;
            end else if (pick < 95) begin
                op = OP_INV;
            end else begin
                op = OP_NONE;
            end
            send_cmd(op, random_operand(), random_operand());
        end
    endtask

    initial begin
        logic [7:0]  poly_plan [12] = '{8'h1B, 8'h00, 8'h1D, 8'h00, 8'hFF, 8'h2B,
                                        8'h1B, 8'h00, 8'hFF, 8'h1D, 8'h1B, 8'h00};
        logic [7:0]  poly;
        int unsigned idle_pct;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(OP_ADD, 8'h00, 8'h00);
        send_cmd(OP_ADD, 8'hFF, 8'hFF);
        send_cmd(OP_ADD, 8'hAA, 8'h55);
        send_cmd(OP_MUL, 8'hFF, 8'hFF);
        send_cmd(OP_MUL, 8'h80, 8'h02);
        send_cmd(OP_MUL, 8'h00, 8'hFF);
        send_cmd(OP_MUL, 8'h57, 8'h83);
        send_cmd(OP_INV, 8'h00, 8'hFF);
        send_cmd(OP_INV, 8'h01, 8'h00);
        send_cmd(OP_INV, 8'hFF, 8'h00);
        send_cmd(OP_INV, 8'h53, 8'hFF);
        send_cmd(OP_INV, 8'h80, 8'h00);
        send_cmd(OP_NONE, 8'hFF, 8'hFF);
        send_cmd(OP_NONE, 8'h00, 8'h00);

        write_poly(8'h00);
        send_cmd(OP_INV, 8'h02, 8'h00);
        send_cmd(OP_INV, 8'h01, 8'h00);
        send_cmd(OP_INV, 8'h03, 8'h00);
        send_cmd(OP_MUL, 8'hFF, 8'hFF);

        write_poly(8'hFF);
        send_cmd(OP_INV, 8'h07, 8'h00);
        send_cmd(OP_INV, 8'h49, 8'h00);
        send_cmd(OP_INV, 8'hFF, 8'h00);
        send_cmd(OP_MUL, 8'hFF, 8'hFF);

        for (int blk = 0; blk < 12; blk++) begin
            poly     = (blk % 4 == 3) ? 8'($urandom) : poly_plan[blk];
            idle_pct = (blk < 4) ? 19 : ((blk < 8) ? 64 : 0);
            write_poly(poly);
            random_block(BlockItems, idle_pct);
        end

        hold_off(1);
        while (board.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        if (board.pending_results.size() != 0) begin
            board.report_mismatch($sformatf("%0d expected results never arrived",
                                            board.pending_results.size()));
        end

        if (board.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
